@@ sv/pne_pkg.sv @@
// Shared constants and types of the point map normal estimator.
// Depends on nothing; pne_if and the top level import it.
package pne_pkg;

	localparam int PNE_MAX_WIDTH        = 1024;
	localparam int PNE_POINT_BITS       = 24;
	localparam int PNE_NORMAL_FRAC_BITS = 14;

	localparam int MAX_HEIGHT  = 4096;
	localparam int NORMAL_BITS = 16;
	localparam int COL_BITS    = 10;
	localparam int ROW_BITS    = 12;
	localparam int IW_BITS     = 11;
	localparam int IH_BITS     = 13;
	localparam int PADDR_BITS  = 3;
	localparam int PDATA_BITS  = 32;

	localparam logic [IW_BITS-1:0] IMAGE_WIDTH_RST  = IW_BITS'(640);
	localparam logic [IH_BITS-1:0] IMAGE_HEIGHT_RST = IH_BITS'(480);

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_index_t;

endpackage

@@ sv/pne_if.sv @@
// Stream interfaces of the normal estimator: point input and normal output.
// Depends on pne_pkg.
interface pne_point_if import pne_pkg::*; #(
	parameter int POINT_BITS = PNE_POINT_BITS
);
	logic                         valid;
	logic                         ready;
	logic signed [POINT_BITS-1:0] point_x;
	logic signed [POINT_BITS-1:0] point_y;
	logic signed [POINT_BITS-1:0] point_z;

	modport source(output valid, point_x, point_y, point_z, input ready);
	modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

interface pne_normal_if import pne_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [NORMAL_BITS-1:0] normal_x;
	logic signed [NORMAL_BITS-1:0] normal_y;
	logic signed [NORMAL_BITS-1:0] normal_z;
	logic                          normal_valid;
	logic [COL_BITS-1:0]           out_col;
	logic [ROW_BITS-1:0]           out_row;
	logic                          frame_last;
	logic                          run_last;

	modport source(output valid, normal_x, normal_y, normal_z, normal_valid, out_col,
		out_row, frame_last, run_last, input ready);
	modport sink(input valid, normal_x, normal_y, normal_z, normal_valid, out_col,
		out_row, frame_last, run_last, output ready);
endinterface

@@ sv/pne_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read per cycle.
// Depends on nothing.
module pne_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/point_map_normal_estimator.sv @@
// Top level of the point map normal estimator: sequencer, row store, arithmetic.
// Depends on pne_pkg, pne_if (pne_point_if, pne_normal_if) and pne_ram.
//
//  channel   | kind         | direction | carries
//  ----------+--------------+-----------+----------------------------------------
//  points    | valid/ready  | in        | point_x, point_y, point_z
//  normals   | valid/ready  | out       | normal xyz, normal_valid, col, row, flags
//  apb       | psel/penable | in        | image_width (0x0), image_height (0x4)
//
// One item is taken at a time. An item costs one row store write plus, for each
// result it causes (zero to three), a neighbor fetch, the cross product and, for a
// valid window, normalization, the 32-step square root and the bit-serial divider.
// Reset clears the position counters and sequencer; the row store holds no reset
// value. A stalled result register only stops the sequencer at the point where it
// would hand over the next result.
module point_map_normal_estimator import pne_pkg::*; #(
	parameter int MAX_WIDTH        = PNE_MAX_WIDTH,
	parameter int POINT_BITS       = PNE_POINT_BITS,
	parameter int NORMAL_FRAC_BITS = PNE_NORMAL_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pne_point_if.sink             points,
	pne_normal_if.source          normals,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready
);

	localparam int CW         = $clog2(MAX_WIDTH);
	localparam int AW         = $clog2(2 * MAX_WIDTH);
	localparam int PW         = 3 * POINT_BITS;
	localparam int DIFF_SHIFT = (POINT_BITS > 30) ? POINT_BITS - 30 : 0;
	localparam int DW         = POINT_BITS + 1 - DIFF_SHIFT;
	localparam int CXW        = 2 * DW + 1;
	localparam int AMW        = (CXW > 31) ? CXW : 31;
	localparam int QB         = NORMAL_FRAC_BITS + 1;
	localparam int QCW        = $clog2(QB + 1);
	localparam int REMW       = 33 + NORMAL_FRAC_BITS;
	localparam logic [QB-1:0] ONE_Q = QB'(1) << NORMAL_FRAC_BITS;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FETCH, ST_DRAIN, ST_MUL, ST_ABS, ST_NORM, ST_SQ, ST_SQRT_LD,
		ST_SQRT, ST_DIV_LD, ST_DIV, ST_DIV_ST, ST_EMIT, ST_WRITE
	} state_t;

	// Which pixel a result belongs to: row above the input, left of the input in the
	// last row, or the input pixel itself at the end of the frame.
	typedef enum logic [1:0] {JOB_UPPER, JOB_LEFT, JOB_SELF} job_t;
	typedef enum logic [1:0] {SRC_RAM, SRC_P, SRC_CTR} src_t;
	typedef enum logic [1:0] {SLOT_CTR, SLOT_LFT, SLOT_RGT, SLOT_ABV} slot_t;

	// configuration
	logic [IW_BITS-1:0] img_w_q;
	logic [IH_BITS-1:0] img_h_q;
	logic               cfg_wr;

	// control
	state_t              state_q;
	job_t                job_q;
	slot_t               rd_k_q;
	logic                cap_v_s1;
	slot_t               cap_k_s1;
	src_t                cap_src_s1;
	logic [CW-1:0]       col_count_q;
	logic [ROW_BITS-1:0] row_count_q;
	logic [CW-1:0]       x_q;
	logic [ROW_BITS-1:0] y_q;
	logic                do_b_q, do_c_q;
	logic [3:0]          mj_q;
	logic                mul_v_s1;
	logic [3:0]          mul_j_s1;
	logic [QCW-1:0]      qc_q;
	logic [1:0]          dk_q;
	logic                out_v_q;

	// datapath
	logic signed [POINT_BITS-1:0] p_q   [3];
	logic signed [POINT_BITS-1:0] win_q [4][3];
	logic signed [POINT_BITS-1:0] blw_q [3];
	logic signed [63:0]           prod_s1;
	logic signed [CXW-1:0]        c_q   [3];
	logic [AMW-1:0]               a_q   [3];
	logic [AMW-1:0]               m_q;
	logic                         neg_q [3];
	logic                         nv_q;
	logic [61:0]                  s_q;
	logic [63:0]                  sv_q, res_q, bit_q;
	logic [REMW-1:0]              rem_q, dv_q;
	logic [QB-1:0]                q_q;
	logic [NORMAL_BITS-1:0]       nrm_q [3];

	// combinational
	logic                in_acc;
	logic [CW-1:0]       wm1;
	logic [ROW_BITS-1:0] hm1;
	logic [CW-1:0]       x_c;
	logic [ROW_BITS-1:0] y_c;
	logic [CW-1:0]       xl1, xr1, xl2;
	logic                rd_par;
	logic [CW-1:0]       rd_col;
	src_t                rd_src;
	logic [AW-1:0]       ram_raddr, ram_waddr;
	logic [PW-1:0]       ram_rdata, ram_wdata;
	logic                ram_we;
	logic signed [POINT_BITS:0] df1 [3];
	logic signed [POINT_BITS:0] df2 [3];
	logic signed [DW-1:0] d1 [3];
	logic signed [DW-1:0] d2 [3];
	logic signed [31:0]  opa, opb;
	logic                mul_issue;
	logic                win_ok;
	logic [63:0]         m64;
	logic [63:0]         sq_trial;
	logic [31:0]         r_c;
	logic [QB-1:0]       q_cl;
	logic [31:0]         q_sgn;

	function automatic logic [AW-1:0] row_addr(input logic par, input logic [CW-1:0] col);
		row_addr = par ? AW'(MAX_WIDTH) + AW'(col) : AW'(col);
	endfunction

	// ---------------------------------------------------------------- config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (reg_index_t'(paddr[2]))
			REG_IMAGE_WIDTH:  prdata = PDATA_BITS'(img_w_q);
			REG_IMAGE_HEIGHT: prdata = PDATA_BITS'(img_h_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= IMAGE_WIDTH_RST;
			img_h_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_wr) begin
			case (reg_index_t'(paddr[2]))
				REG_IMAGE_WIDTH:  img_w_q <= pwdata[IW_BITS-1:0];
				REG_IMAGE_HEIGHT: img_h_q <= pwdata[IH_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- frame geometry
	// Zero size acts as one; a width above the store width or a height above MAX_HEIGHT acts as that limit.
	always_comb begin
		if (img_w_q == '0) begin
			wm1 = '0;
		end else if (32'(img_w_q) > MAX_WIDTH) begin
			wm1 = CW'(MAX_WIDTH - 1);
		end else begin
			wm1 = CW'(img_w_q - IW_BITS'(1));
		end
		if (img_h_q == '0) begin
			hm1 = '0;
		end else if (32'(img_h_q) > MAX_HEIGHT) begin
			hm1 = ROW_BITS'(MAX_HEIGHT - 1);
		end else begin
			hm1 = ROW_BITS'(img_h_q - IH_BITS'(1));
		end
	end

	// A position past the size (after a size change mid-frame) is the last one.
	assign x_c = (col_count_q < wm1) ? col_count_q : wm1;
	assign y_c = (row_count_q < hm1) ? row_count_q : hm1;

	assign in_acc        = points.valid && points.ready;
	assign points.ready  = (state_q == ST_IDLE);

	// ---------------------------------------------------------------- row store
	assign xl1 = (x_q != '0) ? x_q - CW'(1) : '0;
	assign xr1 = (x_q < wm1) ? x_q + CW'(1) : wm1;
	assign xl2 = (x_q >= CW'(2)) ? x_q - CW'(2) : '0;

	// Neighbor fetch plan per result. Slots that need no read take the incoming point or
	// the fetched center instead.
	always_comb begin
		rd_par = ~y_q[0];
		rd_col = x_q;
		rd_src = SRC_RAM;
		case (job_q)
			JOB_UPPER: begin
				case (rd_k_q)
					SLOT_CTR: rd_col = x_q;
					SLOT_LFT: rd_col = xl1;
					SLOT_RGT: rd_col = xr1;
					SLOT_ABV: begin
						rd_par = y_q[0];
						rd_src = (y_q >= ROW_BITS'(2)) ? SRC_RAM : SRC_CTR;
					end
					default: ;
				endcase
			end
			JOB_LEFT: begin
				rd_par = y_q[0];
				case (rd_k_q)
					SLOT_CTR: rd_col = x_q - CW'(1);
					SLOT_LFT: rd_col = xl2;
					SLOT_RGT: rd_src = SRC_P;
					SLOT_ABV: begin
						rd_par = ~y_q[0];
						rd_col = x_q - CW'(1);
						rd_src = (y_q != '0) ? SRC_RAM : SRC_CTR;
					end
					default: ;
				endcase
			end
			JOB_SELF: begin
				rd_par = y_q[0];
				case (rd_k_q)
					SLOT_CTR: rd_src = SRC_P;
					SLOT_LFT: rd_col = xl1;
					SLOT_RGT: rd_src = SRC_P;
					SLOT_ABV: begin
						rd_par = ~y_q[0];
						rd_src = (y_q != '0) ? SRC_RAM : SRC_P;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign ram_raddr = row_addr(rd_par, rd_col);
	assign ram_we    = (state_q == ST_WRITE);
	assign ram_waddr = row_addr(y_q[0], x_q);
	assign ram_wdata = {p_q[2], p_q[1], p_q[0]};

	pne_ram #(
		.WIDTH(PW),
		.DEPTH(2 * MAX_WIDTH)
	) u_row_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ---------------------------------------------------------------- arithmetic
	// Differences right - left and below - above, floored down to multiplier width.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			df1[i] = (POINT_BITS+1)'(win_q[SLOT_RGT][i]) - (POINT_BITS+1)'(win_q[SLOT_LFT][i]);
			df2[i] = (POINT_BITS+1)'(blw_q[i]) - (POINT_BITS+1)'(win_q[SLOT_ABV][i]);
			d1[i]  = DW'(df1[i] >>> DIFF_SHIFT);
			d2[i]  = DW'(df2[i] >>> DIFF_SHIFT);
		end
	end

	assign win_ok = (win_q[SLOT_CTR][2] != '0) && (win_q[SLOT_LFT][2] != '0) &&
		(win_q[SLOT_RGT][2] != '0) && (win_q[SLOT_ABV][2] != '0) && (blw_q[2] != '0);

	// One shared multiplier: six cross-product terms, then three squares.
	assign mul_issue = ((state_q == ST_MUL) && (mj_q <= 4'd5)) ||
		((state_q == ST_SQ) && (mj_q <= 4'd8));

	always_comb begin
		case (mj_q)
			4'd0:    begin opa = 32'(d1[1]); opb = 32'(d2[2]); end
			4'd1:    begin opa = 32'(d1[2]); opb = 32'(d2[1]); end
			4'd2:    begin opa = 32'(d1[2]); opb = 32'(d2[0]); end
			4'd3:    begin opa = 32'(d1[0]); opb = 32'(d2[2]); end
			4'd4:    begin opa = 32'(d1[0]); opb = 32'(d2[1]); end
			4'd5:    begin opa = 32'(d1[1]); opb = 32'(d2[0]); end
			4'd6:    begin opa = 32'(a_q[0][29:0]); opb = 32'(a_q[0][29:0]); end
			4'd7:    begin opa = 32'(a_q[1][29:0]); opb = 32'(a_q[1][29:0]); end
			4'd8:    begin opa = 32'(a_q[2][29:0]); opb = 32'(a_q[2][29:0]); end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	assign m64      = 64'(m_q);
	assign sq_trial = res_q + bit_q;
	assign r_c      = res_q[31:0];
	assign q_cl     = (q_q > ONE_Q) ? ONE_Q : q_q;
	assign q_sgn    = neg_q[0] ? -(32'(q_cl)) : 32'(q_cl);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			p_q[0] <= points.point_x;
			p_q[1] <= points.point_y;
			p_q[2] <= points.point_z;
		end

		// capture fetched neighbors in the cycle after their read
		if (cap_v_s1) begin
			case (cap_src_s1)
				SRC_RAM: begin
					win_q[cap_k_s1][0] <= ram_rdata[POINT_BITS-1:0];
					win_q[cap_k_s1][1] <= ram_rdata[2*POINT_BITS-1:POINT_BITS];
					win_q[cap_k_s1][2] <= ram_rdata[PW-1:2*POINT_BITS];
				end
				SRC_P:   win_q[cap_k_s1] <= p_q;
				SRC_CTR: win_q[cap_k_s1] <= win_q[SLOT_CTR];
				default: ;
			endcase
		end
		if (state_q == ST_DRAIN) begin
			if (job_q == JOB_LEFT) begin
				blw_q <= win_q[SLOT_CTR];
			end else begin
				blw_q <= p_q;
			end
		end

		if (mul_issue) begin
			prod_s1 <= opa * opb;
		end
		if (mul_v_s1) begin
			case (mul_j_s1)
				4'd0:    c_q[0] <= CXW'(prod_s1);
				4'd1:    c_q[0] <= c_q[0] - CXW'(prod_s1);
				4'd2:    c_q[1] <= CXW'(prod_s1);
				4'd3:    c_q[1] <= c_q[1] - CXW'(prod_s1);
				4'd4:    c_q[2] <= CXW'(prod_s1);
				4'd5:    c_q[2] <= c_q[2] - CXW'(prod_s1);
				4'd6:    s_q <= 62'(prod_s1);
				4'd7:    s_q <= s_q + 62'(prod_s1);
				4'd8:    s_q <= s_q + 62'(prod_s1);
				default: ;
			endcase
		end

		case (state_q)
			ST_ABS: begin
				for (int i = 0; i < 3; i++) begin
					a_q[i]   <= AMW'(c_q[i][CXW-1] ? unsigned'(-c_q[i]) : unsigned'(c_q[i]));
					neg_q[i] <= c_q[i][CXW-1];
				end
				if (unsigned'(c_q[1][CXW-1] ? -c_q[1] : c_q[1]) >
						unsigned'(c_q[0][CXW-1] ? -c_q[0] : c_q[0]) &&
						unsigned'(c_q[1][CXW-1] ? -c_q[1] : c_q[1]) >=
						unsigned'(c_q[2][CXW-1] ? -c_q[2] : c_q[2])) begin
					m_q <= AMW'(unsigned'(c_q[1][CXW-1] ? -c_q[1] : c_q[1]));
				end else if (unsigned'(c_q[2][CXW-1] ? -c_q[2] : c_q[2]) >
						unsigned'(c_q[0][CXW-1] ? -c_q[0] : c_q[0]) &&
						unsigned'(c_q[2][CXW-1] ? -c_q[2] : c_q[2]) >
						unsigned'(c_q[1][CXW-1] ? -c_q[1] : c_q[1])) begin
					m_q <= AMW'(unsigned'(c_q[2][CXW-1] ? -c_q[2] : c_q[2]));
				end else begin
					m_q <= AMW'(unsigned'(c_q[0][CXW-1] ? -c_q[0] : c_q[0]));
				end
				nv_q <= win_ok;
				if (!win_ok) begin
					nrm_q[0] <= '0;
					nrm_q[1] <= '0;
					nrm_q[2] <= '0;
				end
			end
			ST_NORM: begin
				// bring the largest magnitude into [2^29, 2^30), coarse then fine
				if (m64 == '0) begin
					nrm_q[0] <= '0;
					nrm_q[1] <= '0;
					nrm_q[2] <= '0;
				end else if (m64 >= (64'(1) << 34)) begin
					m_q <= m_q >> 4;
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 4;
				end else if (m64 >= (64'(1) << 30)) begin
					m_q <= m_q >> 1;
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 1;
				end else if (m64 < (64'(1) << 25)) begin
					m_q <= m_q << 4;
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 4;
				end else if (m64 < (64'(1) << 29)) begin
					m_q <= m_q << 1;
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 1;
				end
			end
			ST_SQRT_LD: begin
				sv_q  <= 64'(s_q);
				res_q <= '0;
				bit_q <= 64'(1) << 62;
			end
			ST_SQRT: begin
				if (sv_q >= sq_trial) begin
					sv_q  <= sv_q - sq_trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DIV_LD: begin
				// rounded quotient: (a << frac + r/2) / r
				rem_q <= (REMW'(a_q[0][29:0]) << NORMAL_FRAC_BITS) + REMW'(r_c >> 1);
				dv_q  <= REMW'(r_c) << NORMAL_FRAC_BITS;
				q_q   <= '0;
			end
			ST_DIV: begin
				if (rem_q >= dv_q) begin
					rem_q <= rem_q - dv_q;
					q_q   <= {q_q[QB-2:0], 1'b1};
				end else begin
					q_q   <= {q_q[QB-2:0], 1'b0};
				end
				dv_q <= dv_q >> 1;
			end
			ST_DIV_ST: begin
				// rotate the next component into place, shift the finished one in on top
				nrm_q[2] <= q_sgn[NORMAL_BITS-1:0];
				nrm_q[1] <= nrm_q[2];
				nrm_q[0] <= nrm_q[1];
				a_q[0]   <= a_q[1];
				a_q[1]   <= a_q[2];
				a_q[2]   <= a_q[0];
				neg_q[0] <= neg_q[1];
				neg_q[1] <= neg_q[2];
				neg_q[2] <= neg_q[0];
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= JOB_UPPER;
			rd_k_q      <= SLOT_CTR;
			cap_v_s1    <= 1'b0;
			cap_k_s1    <= SLOT_CTR;
			cap_src_s1  <= SRC_RAM;
			col_count_q <= '0;
			row_count_q <= '0;
			x_q         <= '0;
			y_q         <= '0;
			do_b_q      <= 1'b0;
			do_c_q      <= 1'b0;
			mj_q        <= '0;
			mul_v_s1    <= 1'b0;
			mul_j_s1    <= '0;
			qc_q        <= '0;
			dk_q        <= '0;
			out_v_q     <= 1'b0;
			normals.normal_x     <= '0;
			normals.normal_y     <= '0;
			normals.normal_z     <= '0;
			normals.normal_valid <= 1'b0;
			normals.out_col      <= '0;
			normals.out_row      <= '0;
			normals.frame_last   <= 1'b0;
			normals.run_last     <= 1'b0;
		end else begin
			cap_v_s1   <= (state_q == ST_FETCH);
			cap_k_s1   <= rd_k_q;
			cap_src_s1 <= rd_src;
			mul_v_s1   <= mul_issue;
			mul_j_s1   <= mj_q;
			// drop the result once taken, unless the next one is loaded in this cycle
			if (out_v_q && normals.ready && state_q != ST_EMIT) begin
				out_v_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						x_q    <= x_c;
						y_q    <= y_c;
						do_b_q <= (y_c == hm1) && (x_c != '0);
						do_c_q <= (y_c == hm1) && (x_c == wm1);
						// advance the raster position
						if (x_c >= wm1) begin
							col_count_q <= '0;
							row_count_q <= (y_c >= hm1) ? '0 : y_c + ROW_BITS'(1);
						end else begin
							col_count_q <= x_c + CW'(1);
							row_count_q <= y_c;
						end
						rd_k_q <= SLOT_CTR;
						job_q  <= JOB_UPPER;
						// the upper result must read its rows before the store is overwritten
						state_q <= (y_c != '0) ? ST_FETCH : ST_WRITE;
					end
				end
				ST_FETCH: begin
					rd_k_q <= slot_t'(2'(rd_k_q + 2'd1));
					if (rd_k_q == SLOT_ABV) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					mj_q    <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mj_q == 4'd6) begin
						state_q <= ST_ABS;
					end else begin
						mj_q <= mj_q + 4'd1;
					end
				end
				ST_ABS: begin
					state_q <= win_ok ? ST_NORM : ST_EMIT;
				end
				ST_NORM: begin
					if (m64 == '0) begin
						state_q <= ST_EMIT;
					end else if (m64 >= (64'(1) << 29) && m64 < (64'(1) << 30)) begin
						mj_q    <= 4'd6;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (mj_q == 4'd9) begin
						state_q <= ST_SQRT_LD;
					end else begin
						mj_q <= mj_q + 4'd1;
					end
				end
				ST_SQRT_LD: begin
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (bit_q == 64'd1) begin
						dk_q    <= '0;
						state_q <= ST_DIV_LD;
					end
				end
				ST_DIV_LD: begin
					qc_q    <= QCW'(QB);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					qc_q <= qc_q - QCW'(1);
					if (qc_q == QCW'(1)) begin
						state_q <= ST_DIV_ST;
					end
				end
				ST_DIV_ST: begin
					if (dk_q == 2'd2) begin
						state_q <= ST_EMIT;
					end else begin
						dk_q    <= dk_q + 2'd1;
						state_q <= ST_DIV_LD;
					end
				end
				ST_EMIT: begin
					// hold until the result register is free
					if (!out_v_q || normals.ready) begin
						out_v_q              <= 1'b1;
						normals.normal_x     <= nrm_q[0];
						normals.normal_y     <= nrm_q[1];
						normals.normal_z     <= nrm_q[2];
						normals.normal_valid <= nv_q;
						normals.frame_last   <= (job_q == JOB_SELF);
						rd_k_q               <= SLOT_CTR;
						case (job_q)
							JOB_UPPER: begin
								normals.out_col  <= COL_BITS'(x_q);
								normals.out_row  <= y_q - ROW_BITS'(1);
								normals.run_last <= !do_b_q && !do_c_q;
								state_q          <= ST_WRITE;
							end
							JOB_LEFT: begin
								normals.out_col  <= COL_BITS'(x_q - CW'(1));
								normals.out_row  <= y_q;
								normals.run_last <= !do_c_q;
								job_q            <= JOB_SELF;
								state_q          <= do_c_q ? ST_FETCH : ST_IDLE;
							end
							default: begin
								normals.out_col  <= COL_BITS'(x_q);
								normals.out_row  <= y_q;
								normals.run_last <= 1'b1;
								state_q          <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WRITE: begin
					rd_k_q <= SLOT_CTR;
					if (do_b_q) begin
						job_q   <= JOB_LEFT;
						state_q <= ST_FETCH;
					end else if (do_c_q) begin
						job_q   <= JOB_SELF;
						state_q <= ST_FETCH;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign normals.valid = out_v_q;

	// ---------------------------------------------------------------- checks
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(points.valid && points.ready) |=> !points.ready)
		else $error("second item taken while one is in progress");

	a_mul_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ABS) |-> !mul_v_s1)
		else $error("cross product read before multiplier drained");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT_LD) |-> ((a_q[0] >> 30) == '0 && (a_q[1] >> 30) == '0 &&
		(a_q[2] >> 30) == '0 && (a_q[0][29] || a_q[1][29] || a_q[2][29])))
		else $error("normalized magnitudes out of range");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_LD) |-> (res_q[63:32] == '0 && res_q[31:29] != 3'd0))
		else $error("square root out of range");

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_ST) |-> (q_q <= ONE_Q))
		else $error("normal component above one");

endmodule
